// File: design/asc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and codes for the access sequentiality classifier.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int MAX_ROWS = 3;

    // result row kinds
    typedef enum logic [1:0] {
        KIND_CLASS   = 2'd0,
        KIND_RUN_END = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    // access classes
    typedef enum logic [1:0] {
        CLASS_INITIAL    = 2'd0,
        CLASS_SEQUENTIAL = 2'd1,
        CLASS_RANDOM     = 2'd2
    } access_class_t;

    // input actions
    typedef enum logic {
        ACT_ACCESS    = 1'b0,
        ACT_GROUP_END = 1'b1
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [62:0]        offset;
        logic [30:0]        length;
        logic               is_read;
        logic signed [63:0] fsize;
    } in_item_t;

    typedef struct packed {
        kind_t              kind;
        access_class_t      access_class;
        logic signed [63:0] skip;
        logic [31:0]        reads_done;
        logic [31:0]        writes_done;
        logic [62:0]        read_total;
        logic [62:0]        write_total;
        logic [31:0]        seq_ops;
        logic [62:0]        seq_total;
        logic [31:0]        run_ops;
        logic [62:0]        run_total;
        logic               last;
    } row_t;

    typedef row_t [MAX_ROWS-1:0] row_set_t;

endpackage
`default_nettype wire

// File: design/asc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asc_core
// Classifies one request against the previous end offset, updates the run
// counters and builds up to three result rows in a single pass.
// ----------------------------------------------------------------------------
module asc_core #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire_i,
    input  wire asc_pkg::in_item_t item_i,
    output asc_pkg::row_set_t     rows_o,
    output logic [1:0]            nrows_o
);
    import asc_pkg::*;

    typedef logic [COUNT_BITS-1:0] cnt_t;

    localparam logic [62:0] SUM_MAX = {63{1'b1}};

    // saturating counter step
    function automatic cnt_t inc_cnt(input cnt_t c);
        return (c == {COUNT_BITS{1'b1}}) ? c : c + cnt_t'(1);
    endfunction

    // saturating byte sum
    function automatic logic [62:0] add_sum(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[63] ? SUM_MAX : s[62:0];
    endfunction

    // count shown in a 32-bit field
    function automatic logic [31:0] c32(input cnt_t c);
        logic [63:0] w;
        w = 64'(c);
        return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    // run state
    logic        end_valid_reg, end_valid_next;
    logic [63:0] prev_end_reg, prev_end_next;
    logic [30:0] first_len_reg, first_len_next;
    logic        first_valid_reg, first_valid_next;
    cnt_t        read_ops_reg, read_ops_next;
    cnt_t        write_ops_reg, write_ops_next;
    logic [62:0] read_sum_reg, read_sum_next;
    logic [62:0] write_sum_reg, write_sum_next;
    cnt_t        seq_ops_reg, seq_ops_next;
    cnt_t        rnd_ops_reg, rnd_ops_next;
    logic [62:0] seq_sum_reg, seq_sum_next;
    cnt_t        run_ops_reg, run_ops_next;
    logic [62:0] run_sum_reg, run_sum_next;

    logic        first_class;
    logic        run_row;
    logic        finish;
    logic        report;
    logic [63:0] touched;
    cnt_t        rnd_final;
    logic [62:0] len63;
    row_t        class_row, end_row, sum_row;
    row_set_t    rows;
    logic [1:0]  nrows;

    assign len63 = 63'(item_i.length);

    // classification, counter update and row assembly
    always_comb begin
        end_valid_next   = end_valid_reg;
        prev_end_next    = prev_end_reg;
        first_len_next   = first_len_reg;
        first_valid_next = first_valid_reg;
        read_ops_next    = read_ops_reg;
        write_ops_next   = write_ops_reg;
        read_sum_next    = read_sum_reg;
        write_sum_next   = write_sum_reg;
        seq_ops_next     = seq_ops_reg;
        rnd_ops_next     = rnd_ops_reg;
        seq_sum_next     = seq_sum_reg;
        run_ops_next     = run_ops_reg;
        run_sum_next     = run_sum_reg;
        class_row        = '0;
        end_row          = '0;
        sum_row          = '0;
        rows             = '0;
        nrows            = 2'd0;
        run_row          = 1'b0;
        finish           = 1'b0;
        report           = 1'b0;
        touched          = '0;
        rnd_final        = '0;
        first_class      = (seq_ops_reg == '0) && (rnd_ops_reg == '0);

        if (item_i.action == ACT_ACCESS) begin
            // read and write totals
            if (item_i.is_read) begin
                read_ops_next = inc_cnt(read_ops_reg);
                read_sum_next = add_sum(read_sum_reg, len63);
            end else begin
                write_ops_next = inc_cnt(write_ops_reg);
                write_sum_next = add_sum(write_sum_reg, len63);
            end

            class_row.kind = KIND_CLASS;
            if (end_valid_reg && prev_end_reg == {1'b0, item_i.offset}) begin
                // continues the run; first access joins the count on the first class
                class_row.access_class = CLASS_SEQUENTIAL;
                if (first_class) begin
                    seq_ops_next = cnt_t'(2);
                    seq_sum_next = 63'(first_len_reg) + len63;
                end else begin
                    seq_ops_next = inc_cnt(seq_ops_reg);
                    seq_sum_next = add_sum(seq_sum_reg, len63);
                end
                run_ops_next = inc_cnt(run_ops_reg);
                run_sum_next = add_sum(run_sum_reg, len63);
            end else if (end_valid_reg) begin
                // random jump ends the current run
                class_row.access_class = CLASS_RANDOM;
                class_row.skip         = {1'b0, item_i.offset} - prev_end_reg;
                rnd_ops_next = first_class ? cnt_t'(2) : inc_cnt(rnd_ops_reg);
                if (run_ops_reg != '0) begin
                    run_row           = 1'b1;
                    end_row.kind      = KIND_RUN_END;
                    end_row.run_ops   = c32(run_ops_reg);
                    end_row.run_total = run_sum_reg;
                end
                run_ops_next = cnt_t'(1);
                run_sum_next = len63;
            end else begin
                // first access of a run
                class_row.access_class = CLASS_INITIAL;
                first_len_next   = item_i.length;
                first_valid_next = 1'b1;
                run_ops_next     = cnt_t'(1);
                run_sum_next     = len63;
            end

            prev_end_next  = {1'b0, item_i.offset} + 64'(item_i.length);
            end_valid_next = 1'b1;

            // end of file with at least half the file touched
            touched = {1'b0, read_sum_next} + {1'b0, write_sum_next};
            finish  = !item_i.fsize[63] && (prev_end_next == item_i.fsize) &&
                      ({touched, 1'b0} >= {1'b0, item_i.fsize});
        end else begin
            finish = !first_class || first_valid_reg;
        end

        // run summary from the updated state
        rnd_final = ((seq_ops_next == '0) && (rnd_ops_next == '0)) ?
                    inc_cnt(rnd_ops_next) : rnd_ops_next;
        report = ((read_sum_next != '0) || (write_sum_next != '0)) &&
                 (rnd_final != '0) &&
                 ((rnd_final >= cnt_t'(2)) || (seq_ops_next != '0));
        sum_row.kind        = KIND_SUMMARY;
        sum_row.reads_done  = c32(read_ops_next);
        sum_row.writes_done = c32(write_ops_next);
        sum_row.read_total  = read_sum_next;
        sum_row.write_total = write_sum_next;
        sum_row.seq_ops     = c32(seq_ops_next);
        sum_row.seq_total   = seq_sum_next;
        if (report) begin
            sum_row.run_ops   = c32(run_ops_next);
            sum_row.run_total = run_sum_next;
        end

        // place rows in output order
        if (item_i.action == ACT_ACCESS) begin
            rows[0] = class_row;
            nrows   = 2'd1;
            if (run_row) begin
                rows[1] = end_row;
                nrows   = 2'd2;
            end
        end
        if (finish) begin
            rows[nrows] = sum_row;
            nrows       = nrows + 2'd1;
        end
        if (nrows != 2'd0) begin
            rows[nrows - 2'd1].last = 1'b1;
        end

        // summary clears the run
        if (finish) begin
            end_valid_next   = 1'b0;
            prev_end_next    = '0;
            first_len_next   = '0;
            first_valid_next = 1'b0;
            read_ops_next    = '0;
            write_ops_next   = '0;
            read_sum_next    = '0;
            write_sum_next   = '0;
            seq_ops_next     = '0;
            rnd_ops_next     = '0;
            seq_sum_next     = '0;
            run_ops_next     = '0;
            run_sum_next     = '0;
        end
    end

    assign rows_o  = rows;
    assign nrows_o = nrows;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_valid_reg   <= 1'b0;
            prev_end_reg    <= '0;
            first_len_reg   <= '0;
            first_valid_reg <= 1'b0;
            read_ops_reg    <= '0;
            write_ops_reg   <= '0;
            read_sum_reg    <= '0;
            write_sum_reg   <= '0;
            seq_ops_reg     <= '0;
            rnd_ops_reg     <= '0;
            seq_sum_reg     <= '0;
            run_ops_reg     <= '0;
            run_sum_reg     <= '0;
        end else if (fire_i) begin
            end_valid_reg   <= end_valid_next;
            prev_end_reg    <= prev_end_next;
            first_len_reg   <= first_len_next;
            first_valid_reg <= first_valid_next;
            read_ops_reg    <= read_ops_next;
            write_ops_reg   <= write_ops_next;
            read_sum_reg    <= read_sum_next;
            write_sum_reg   <= write_sum_next;
            seq_ops_reg     <= seq_ops_next;
            rnd_ops_reg     <= rnd_ops_next;
            seq_sum_reg     <= seq_sum_next;
            run_ops_reg     <= run_ops_next;
            run_sum_reg     <= run_sum_next;
        end
    end

    // a classed access implies a known previous end
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((seq_ops_reg != '0) || (rnd_ops_reg != '0)) |-> end_valid_reg)
        else $error("classed accesses without a previous end");

    // an open run always holds at least the access that opened it
    assert property (@(posedge aclk) disable iff (!aresetn)
        end_valid_reg |-> (first_valid_reg && (run_ops_reg != '0)))
        else $error("open run with empty run count");

endmodule
`default_nettype wire

// File: design/asc_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asc_outbuf
// Result register bank: holds the rows of one request and hands them out one
// per cycle with m_ready_i high; refills in the cycle its final row is taken.
// ----------------------------------------------------------------------------
module asc_outbuf (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load_i,
    input  wire asc_pkg::row_set_t rows_i,
    input  wire logic [1:0]     nrows_i,
    output logic                ready_o,
    output logic                m_valid_o,
    input  wire logic           m_ready_i,
    output asc_pkg::row_t       m_row_o
);
    import asc_pkg::*;

    row_set_t   slots_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;
    logic       take;
    logic       at_final;

    assign m_valid_o = (cnt_reg != 2'd0);
    assign m_row_o   = slots_reg[idx_reg];
    assign take      = m_valid_o && m_ready_i;
    assign at_final  = (idx_reg == cnt_reg - 2'd1);
    assign ready_o   = !m_valid_o || (take && at_final);

    // slot pointer and fill count
    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load_i) begin
            cnt_next = nrows_i;
            idx_next = 2'd0;
        end else if (take) begin
            if (at_final) begin
                cnt_next = 2'd0;
                idx_next = 2'd0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // row payload
    always_ff @(posedge aclk) begin
        if (load_i) begin
            slots_reg <= rows_i;
        end
    end

    // pointer stays inside the filled slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 2'd0) |-> ((idx_reg < cnt_reg) && (cnt_reg <= 2'd3)))
        else $error("slot pointer beyond fill count");

    // last flag sits exactly on the final row of a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_o |-> (m_row_o.last == at_final))
        else $error("last flag not on final row");

endmodule
`default_nettype wire

// File: design/access_sequentiality_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// Timing: a request waits in the input register until the result bank loads
//   it. Throughput, with m_tready high: one request per cycle while each
//   request gives one result; the result channel moves one row per cycle,
//   so a request with two or three rows holds the pipe until all are out.
// Reset: aresetn low clears all run counters and both channel registers at
//   once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// access_sequentiality_classifier
// Classifies file accesses as initial, sequential or random, tracks run
// statistics and emits run-ended and run summary rows.
// ----------------------------------------------------------------------------
module access_sequentiality_classifier #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // offset[62:0], length[93:63], is_read[94], fsize[158:95], zero pad
    input  wire logic [159:0] s_tdata,
    // action[0]
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // access_class[1:0], skip[65:2], reads_done[97:66], writes_done[129:98],
    // read_total[192:130], write_total[255:193], seq_ops[287:256],
    // seq_total[350:288], run_ops[382:351], run_total[445:383], zero pad
    output logic [447:0]      m_tdata,
    // kind[1:0]
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import asc_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    in_item_t  in_item;
    logic      fire;
    logic      buf_ready;
    row_set_t  rows;
    logic [1:0] nrows;
    row_t      out_row;

    // unpack the incoming request
    assign in_item.action  = action_t'(s_tuser[0]);
    assign in_item.offset  = s_tdata[62:0];
    assign in_item.length  = s_tdata[93:63];
    assign in_item.is_read = s_tdata[94];
    assign in_item.fsize   = s_tdata[158:95];

    assign fire     = in_valid_reg && buf_ready;
    assign s_tready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item;
        end
    end

    asc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire_i  (fire),
        .item_i  (in_item_reg),
        .rows_o  (rows),
        .nrows_o (nrows)
    );

    asc_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_i    (fire),
        .rows_i    (rows),
        .nrows_i   (nrows),
        .ready_o   (buf_ready),
        .m_valid_o (m_tvalid),
        .m_ready_i (m_tready),
        .m_row_o   (out_row)
    );

    // pack the result row
    assign m_tdata = {2'b00,
                      out_row.run_total,
                      out_row.run_ops,
                      out_row.seq_total,
                      out_row.seq_ops,
                      out_row.write_total,
                      out_row.read_total,
                      out_row.writes_done,
                      out_row.reads_done,
                      out_row.skip,
                      out_row.access_class};
    assign m_tuser = out_row.kind;
    assign m_tlast = out_row.last;

endmodule
`default_nettype wire
